### rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_HOLDS(label, clk, rst, !(cond), msg)

`endif

### rtl/slat_pkg.sv
`timescale 1ns / 1ps

package slat_pkg;

   // Default geometry of the S-box.
   localparam int IN_BITS_DEF  = 4;
   localparam int OUT_BITS_DEF = 4;

   // Fixed widths of the item fields.
   localparam int FIELD_W   = 4;
   localparam int LAT_W     = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Item kinds carried on the request tuser bit.
   typedef enum logic {
      MODE_LOAD    = 1'b0,
      MODE_COMPUTE = 1'b1
   } mode_type;

endpackage

### rtl/sbox_linear_approximation_table.sv
`timescale 1ns / 1ps
// Linear approximation table row engine for a small S-box.
// Request channel (req_*): tuser selects the item kind. A load item writes
// one S-box entry and is done in the cycle it is accepted. A compute item
// names an output mask b and produces one result item per input mask a,
// in ascending order of a, with tlast on the final one.
// Result channel (rsp_*): input mask, echoed output mask and the signed
// Walsh coefficient sum over x of (-1)^(a.x xor b.S(x)).
// A compute item with N = 2^IN_BITS first fills the work memory, reading
// and then writing each entry, runs N/2*IN_BITS butterflies, each read in
// ST_BF_RD and written back in ST_BF_LO and ST_BF_HI, then reads and emits
// one result item after another while the receiver keeps up. The work
// memory's single write port makes the sum and difference separate writes.
// req_tready is low from the accepted compute item until its last result
// sits in the output register; a stalled receiver holds the result item
// and the engine waits for it. Loads may be taken while the last result
// still waits. Reset returns the engine to idle with no result pending;
// the S-box table is undefined until every entry has been loaded.
module sbox_linear_approximation_table
   import slat_pkg::*;
#(
   parameter int IN_BITS  = IN_BITS_DEF,
   parameter int OUT_BITS = OUT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Bits from lowest: sbox_index[3:0], sbox_value[7:4], output_mask[11:8], zero.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Bits from lowest: mode.
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Bits from lowest: input_mask[3:0], out_mask[7:4], lat_value[13:8], zero.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int ROWS   = 1 << IN_BITS;
   localparam int SPEC_W = IN_BITS + 2;
   localparam int STG_W  = (IN_BITS > 2) ? $clog2(IN_BITS) : 1;
   localparam logic [STG_W-1:0] LAST_STG = STG_W'(IN_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_BF_RD,
      ST_BF_LO,
      ST_BF_HI,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

   state_type                 state_ff;
   logic [IN_BITS-1:0]        x_ff;
   logic [IN_BITS-2:0]        pair_ff;
   logic [STG_W-1:0]          stg_ff;
   logic [OUT_BITS-1:0]       mask_ff;
   logic signed [SPEC_W-1:0]  diff_ff;
   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;
   logic                      rsp_tlast_ff;

   logic [OUT_BITS-1:0]       sbox_mem [ROWS];
   logic [OUT_BITS-1:0]       sbox_rd_ff;
   logic signed [SPEC_W-1:0]  spec_mem [ROWS];
   logic signed [SPEC_W-1:0]  spec_a_ff;
   logic signed [SPEC_W-1:0]  spec_b_ff;

   logic                      req_accept;
   logic                      sbox_we;
   logic [IN_BITS-1:0]        pair_ext;
   logic [IN_BITS-1:0]        stg_bit;
   logic [IN_BITS-1:0]        low_mask;
   logic [IN_BITS-1:0]        lo_addr;
   logic [IN_BITS-1:0]        hi_addr;
   logic [IN_BITS-1:0]        raddr_a;
   logic                      spec_we;
   logic [IN_BITS-1:0]        spec_waddr;
   logic signed [SPEC_W-1:0]  spec_wdata;
   logic signed [SPEC_W-1:0]  fill_val;
   logic                      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign sbox_we    = req_accept && (req_tuser == MODE_LOAD);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Butterfly pair addresses: insert a zero, then a one, at the stage bit.
   always_comb begin
      pair_ext = {1'b0, pair_ff};
      stg_bit  = IN_BITS'(1) << stg_ff;
      low_mask = stg_bit - IN_BITS'(1);
      lo_addr  = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
      hi_addr  = lo_addr | stg_bit;
   end

   // Sign of one fill entry from the parity of b AND S(x).
   assign fill_val = (^(mask_ff & sbox_rd_ff)) ? '1 : SPEC_W'(1);

   // Work memory port selection.
   always_comb begin
      raddr_a    = (state_ff == ST_BF_RD) ? lo_addr : x_ff;
      spec_we    = 1'b0;
      spec_waddr = x_ff;
      spec_wdata = fill_val;
      unique case (state_ff)
         ST_FILL_WR: begin
            spec_we = 1'b1;
         end
         ST_BF_LO: begin
            spec_we    = 1'b1;
            spec_waddr = lo_addr;
            spec_wdata = spec_a_ff + spec_b_ff;
         end
         ST_BF_HI: begin
            spec_we    = 1'b1;
            spec_waddr = hi_addr;
            spec_wdata = diff_ff;
         end
         default: begin
            spec_we = 1'b0;
         end
      endcase
   end

   // S-box table: written by load items, read during the fill.
   always_ff @(posedge clock) begin
      if (sbox_we) begin
         sbox_mem[IN_BITS'(req_tdata[FIELD_W-1:0])] <= OUT_BITS'(req_tdata[2*FIELD_W-1:FIELD_W]);
      end
      sbox_rd_ff <= sbox_mem[x_ff];
   end

   // Work memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (spec_we) begin
         spec_mem[spec_waddr] <= spec_wdata;
      end
      spec_a_ff <= spec_mem[raddr_a];
      spec_b_ff <= spec_mem[hi_addr];
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         x_ff          <= '0;
         pair_ff       <= '0;
         stg_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // The emit state reloads the output register itself when it drains.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_EMIT_WAIT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_tuser == MODE_COMPUTE)) begin
                  mask_ff  <= OUT_BITS'(req_tdata[3*FIELD_W-1:2*FIELD_W]);
                  x_ff     <= '0;
                  state_ff <= ST_FILL_RD;
               end
            end
            ST_FILL_RD: begin
               state_ff <= ST_FILL_WR;
            end
            ST_FILL_WR: begin
               x_ff <= x_ff + IN_BITS'(1);
               if (&x_ff) begin
                  pair_ff  <= '0;
                  stg_ff   <= '0;
                  state_ff <= ST_BF_RD;
               end else begin
                  state_ff <= ST_FILL_RD;
               end
            end
            ST_BF_RD: begin
               state_ff <= ST_BF_LO;
            end
            ST_BF_LO: begin
               diff_ff  <= spec_a_ff - spec_b_ff;
               state_ff <= ST_BF_HI;
            end
            ST_BF_HI: begin
               pair_ff <= pair_ff + (IN_BITS-1)'(1);
               if (&pair_ff) begin
                  if (stg_ff == LAST_STG) begin
                     x_ff     <= '0;
                     state_ff <= ST_EMIT_RD;
                  end else begin
                     stg_ff   <= stg_ff + STG_W'(1);
                     state_ff <= ST_BF_RD;
                  end
               end else begin
                  state_ff <= ST_BF_RD;
               end
            end
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {{(RSP_DATA_W - 2*FIELD_W - LAT_W){1'b0}},
                                    LAT_W'(spec_a_ff), FIELD_W'(mask_ff), FIELD_W'(x_ff)};
                  rsp_tlast_ff  <= &x_ff;
                  x_ff          <= x_ff + IN_BITS'(1);
                  state_ff      <= (&x_ff) ? ST_IDLE : ST_EMIT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

### rtl/slat_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slat_checker
   import slat_pkg::*;
#(
   parameter int IN_BITS = IN_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   localparam logic [FIELD_W-1:0] LAST_MASK = FIELD_W'((1 << IN_BITS) - 1);

   // A stalled result item holds its payload.
   `ASSERT_HOLDS(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result item changed while stalled")

   // A compute item keeps the request side closed in the next cycle.
   `ASSERT_HOLDS(a_busy_after_compute, clock, reset, req_tvalid && req_tready && req_tuser == MODE_COMPUTE |=> !req_tready, "request taken during a row")

   // The last item of a row carries the highest input mask.
   `ASSERT_HOLDS(a_last_mask, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tdata[FIELD_W-1:0] == LAST_MASK, "tlast on wrong input mask")

   // Every Walsh coefficient of a full row is even.
   `ASSERT_NEVER(a_even_coeff, clock, reset, rsp_tvalid && rsp_tdata[2*FIELD_W], "odd coefficient")

endmodule

bind sbox_linear_approximation_table slat_checker #(.IN_BITS(IN_BITS)) u_slat_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import slat_pkg::*;

   localparam int ROW_LEN      = 16;
   localparam int RANDOM_ITEMS = 240;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;

   // One request item as the sender sees it.
   typedef struct {
      mode_type   mode;
      logic [3:0] sbox_index;
      logic [3:0] sbox_value;
      logic [3:0] output_mask;
   } lat_request_type;

   // One entry of a computed LAT row.
   typedef struct {
      logic [3:0]        input_mask;
      logic [3:0]        out_mask;
      logic signed [5:0] lat_value;
      logic              last;
   } lat_coeff_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   lat_request_type pending_requests[$];
   lat_coeff_type   expected_entries[$];
   logic [3:0]      sbox_copy[ROW_LEN];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int issue_count    = 0;
   int accept_count   = 0;
   int quiet_cycles   = 0;
   int error_count    = 0;
   int load_count     = 0;
   int row_count      = 0;
   int entry_count    = 0;

   sbox_linear_approximation_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic lat_request_type make_request(input mode_type mode, input logic [3:0] idx,
                                                    input logic [3:0] val,
                                                    input logic [3:0] mask);
      lat_request_type r;
      r.mode        = mode;
      r.sbox_index  = idx;
      r.sbox_value  = val;
      r.output_mask = mask;
      return r;
   endfunction

   function automatic lat_request_type random_request();
      mode_type m;
      m = ($urandom_range(0, 99) < 35) ? MODE_COMPUTE : MODE_LOAD;
      return make_request(m, 4'($urandom), 4'($urandom), 4'($urandom));
   endfunction

   // A load updates the local S-box copy; a compute queues the whole row of
   // Walsh coefficients, each summed directly over every input x.
   function automatic void predict_lat_row(input lat_request_type r);
      int             a;
      int             x;
      int             coeff;
      logic [3:0]     am;
      logic [3:0]     xm;
      lat_coeff_type  e;
      if (r.mode == MODE_LOAD) begin
         sbox_copy[r.sbox_index] = r.sbox_value;
         load_count++;
      end else begin
         row_count++;
         for (a = 0; a < ROW_LEN; a++) begin
            am = a[3:0];
            coeff = 0;
            for (x = 0; x < ROW_LEN; x++) begin
               xm = x[3:0];
               coeff += ((^(am & xm)) ^ (^(r.output_mask & sbox_copy[x]))) ? -1 : 1;
            end
            e.input_mask = am;
            e.out_mask   = r.output_mask;
            e.lat_value  = 6'(coeff);
            e.last       = (a == ROW_LEN - 1);
            expected_entries.push_back(e);
         end
      end
   endfunction

   // Compare one received entry with the oldest expected one.
   function automatic void check_lat_entry(input lat_coeff_type got);
      lat_coeff_type want;
      if (expected_entries.size() == 0) begin
         $display("%0t: unexpected entry a=%0d b=%0d lat=%0d last=%0b", $time,
                  got.input_mask, got.out_mask, got.lat_value, got.last);
         error_count++;
         return;
      end
      want = expected_entries.pop_front();
      entry_count++;
      if (got.input_mask !== want.input_mask) begin
         $display("%0t: input_mask expected %0d actual %0d", $time,
                  want.input_mask, got.input_mask);
         error_count++;
      end
      if (got.out_mask !== want.out_mask) begin
         $display("%0t: out_mask expected %0d actual %0d", $time, want.out_mask, got.out_mask);
         error_count++;
      end
      if (got.lat_value !== want.lat_value) begin
         $display("%0t: lat_value (a=%0d b=%0d) expected %0d actual %0d", $time,
                  want.input_mask, want.out_mask, want.lat_value, got.lat_value);
         error_count++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last (a=%0d) expected %0b actual %0b", $time,
                  want.input_mask, want.last, got.last);
         error_count++;
      end
   endfunction

   // Driver: presents the next pending item once the previous one was taken,
   // and sets the receiver's ready for the coming edge.
   always @(negedge clock) begin : driver
      lat_request_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (accept_count == issue_count) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               r = pending_requests.pop_front();
               req_tvalid  <= 1'b1;
               req_tuser   <= r.mode;
               req_tdata   <= {4'b0, r.output_mask, r.sbox_value, r.sbox_index};
               issue_count <= issue_count + 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted result
   // and ends the run if nothing moves for too long.
   always @(posedge clock) begin : monitor
      lat_coeff_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accept_count <= accept_count + 1;
            predict_lat_row(make_request(mode_type'(req_tuser), req_tdata[3:0],
                                         req_tdata[7:4], req_tdata[11:8]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.input_mask = rsp_tdata[3:0];
            got.out_mask   = rsp_tdata[7:4];
            got.lat_value  = rsp_tdata[13:8];
            got.last       = rsp_tlast;
            check_lat_entry(got);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus: fill the whole S-box first so no compute reads an unloaded
   // entry, then random traffic under four idling phases.
   initial begin : stimulus
      int phase;
      int k;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 9;
               recv_stall_pct = 9;
            end
         endcase
         if (phase == 0) begin
            // A permutation that holds both 0 and 15 as values.
            for (k = 0; k < ROW_LEN; k++) begin
               pending_requests.push_back(make_request(MODE_LOAD, k[3:0],
                                                       4'(k * 7 + 3), 4'hF));
            end
            pending_requests.push_back(make_request(MODE_COMPUTE, 4'h0, 4'h0, 4'h0));
            pending_requests.push_back(make_request(MODE_COMPUTE, 4'hF, 4'hF, 4'hF));
            pending_requests.push_back(make_request(MODE_COMPUTE, 4'h0, 4'h0, 4'h1));
            pending_requests.push_back(make_request(MODE_COMPUTE, 4'h0, 4'h0, 4'h8));
            // Collapse one entry so the rows are no longer balanced.
            pending_requests.push_back(make_request(MODE_LOAD, 4'hF, 4'h3, 4'h0));
            pending_requests.push_back(make_request(MODE_COMPUTE, 4'h0, 4'h0, 4'h5));
            pending_requests.push_back(make_request(MODE_COMPUTE, 4'h0, 4'h0, 4'hF));
         end
         for (k = 0; k < RANDOM_ITEMS / 4; k++) begin
            pending_requests.push_back(random_request());
         end
         while (pending_requests.size() != 0 || accept_count != issue_count) begin
            @(posedge clock);
         end
      end
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d S-box loads and %0d LAT rows, %0d entries checked.",
               load_count, row_count, entry_count);
      $display("Idling phases: none, sender idle, receiver stalled, both lightly.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
